>>> design/rrif_pkg.sv
package rrif_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [1:0] {
    ACT_ENABLE  = 2'd0,
    ACT_DISABLE = 2'd1,
    ACT_FIRE    = 2'd2,
    ACT_NOP     = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_NONE      = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } fsm_t;

  typedef struct packed {
    logic [1:0] action;
    logic [8:0] exc_num;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        fired;
    logic [8:0]  fired_num;
    logic [31:0] round_count;
  } result_t;

  typedef struct packed {
    logic       enabled;
    logic [8:0] num;
  } entry_t;

endpackage

>>> design/round_robin_interrupt_firer_core.sv
// Channel   Ports                      Direction  Handshake
// command   start, busy, cmd           in         beat taken when start && !busy
// result    done, result               out        beat shown for one cycle with done
//
// The table lives in a one-port-write, one-port-read memory with a registered read.
// Enable, disable and fire scan the table one entry per cycle; the result beat
// follows in the next cycle. An empty table or the unused action code is answered
// from idle without a scan.
// Reset clears the entry count, pointer, round counter and control state.
// The receiver cannot stall; a new command may be taken while a result is shown.
module round_robin_interrupt_firer_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  rrif_pkg::cmd_t    cmd,
  output logic             done,
  output rrif_pkg::result_t result
);
  import rrif_pkg::*;

  entry_t mem [MAX_ENTRIES];
  entry_t rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t wr_data;

  fsm_t state, state_next;
  logic [1:0] act;
  logic [8:0] num;
  logic [IDX_W-1:0] cur, cur_next;
  logic [CNT_W-1:0] visited, visited_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] ptr, ptr_next;
  logic [31:0] rounds, rounds_next;
  logic done_next;
  result_t result_next;

  logic [CNT_W-1:0] count_m1;
  logic is_end, is_last;
  logic [IDX_W-1:0] nxt;
  logic [IDX_W-1:0] start_idx;
  logic [31:0] r_step;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  assign count_m1 = CNT_W'(count - CNT_W'(1));
  assign is_end   = (CNT_W'(cur) == count_m1);
  assign is_last  = (visited == count);
  assign nxt      = is_end ? '0 : IDX_W'(cur + IDX_W'(1));
  assign start_idx = (CNT_W'(ptr) >= count) ? '0 : ptr;
  assign busy     = (state != S_IDLE);

  always_comb begin
    state_next   = state;
    cur_next     = cur;
    visited_next = visited;
    count_next   = count;
    ptr_next     = ptr;
    rounds_next  = rounds;
    done_next    = 1'b0;
    result_next  = result;
    rd_addr      = cur;
    wr_en        = 1'b0;
    wr_addr      = cur;
    wr_data      = rd_data;
    r_step       = rounds;

    case (state)
      S_IDLE: begin
        if (start) begin
          result_next.status      = ST_OK;
          result_next.fired       = 1'b0;
          result_next.fired_num   = '0;
          result_next.round_count = rounds;
          if (cmd.action == ACT_NOP) begin
            done_next = 1'b1;
          end else if (count == '0) begin
            done_next = 1'b1;
            case (cmd.action)
              ACT_ENABLE: begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = '{enabled: 1'b1, num: cmd.exc_num};
                count_next = CNT_W'(1);
              end
              ACT_DISABLE: begin
                result_next.status = ST_NOT_FOUND;
              end
              default: begin
                rounds_next             = rounds + 32'd1;
                result_next.status      = ST_NONE;
                result_next.round_count = rounds + 32'd1;
              end
            endcase
          end else begin
            if (cmd.action == ACT_FIRE) begin
              rd_addr  = start_idx;
              cur_next = start_idx;
              ptr_next = start_idx;
            end else begin
              rd_addr  = '0;
              cur_next = '0;
            end
            visited_next = CNT_W'(1);
            state_next   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_addr = nxt;
        case (act)
          ACT_FIRE: begin
            r_step = is_end ? rounds + 32'd1 : rounds;
            rounds_next = r_step;
            if (rd_data.enabled) begin
              done_next               = 1'b1;
              state_next              = S_IDLE;
              result_next.fired       = 1'b1;
              result_next.fired_num   = rd_data.num;
              result_next.round_count = r_step;
              ptr_next                = nxt;
            end else if (is_last) begin
              done_next               = 1'b1;
              state_next              = S_IDLE;
              rounds_next             = r_step + 32'd1;
              result_next.status      = ST_NONE;
              result_next.round_count = r_step + 32'd1;
            end
          end
          ACT_ENABLE: begin
            if (rd_data.num == num) begin
              done_next  = 1'b1;
              state_next = S_IDLE;
              wr_en      = 1'b1;
              wr_addr    = cur;
              wr_data    = '{enabled: 1'b1, num: rd_data.num};
            end else if (is_last) begin
              done_next  = 1'b1;
              state_next = S_IDLE;
              if (count == CNT_W'(MAX_ENTRIES)) begin
                result_next.status = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = count[IDX_W-1:0];
                wr_data    = '{enabled: 1'b1, num: num};
                count_next = CNT_W'(count + CNT_W'(1));
              end
            end
          end
          default: begin
            if (rd_data.num == num) begin
              done_next  = 1'b1;
              state_next = S_IDLE;
              wr_en      = 1'b1;
              wr_addr    = cur;
              wr_data    = '{enabled: 1'b0, num: rd_data.num};
            end else if (is_last) begin
              done_next          = 1'b1;
              state_next         = S_IDLE;
              result_next.status = ST_NOT_FOUND;
            end
          end
        endcase
        if (state_next == S_SCAN) begin
          cur_next     = nxt;
          visited_next = CNT_W'(visited + CNT_W'(1));
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      ptr    <= '0;
      rounds <= '0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      ptr    <= ptr_next;
      rounds <= rounds_next;
      done   <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    result  <= result_next;
    cur     <= cur_next;
    visited <= visited_next;
    if (start && !busy) begin
      act <= cmd.action;
      num <= cmd.exc_num;
    end
  end

endmodule
